/* hw/rtl/mexp_pkg.sv */
// Shared types and constants of the modular exponentiation block.
`timescale 1ns / 1ps

package mexp_pkg;

	// Modulus loaded at reset, the prime 1e9 + 7.
	localparam logic [31:0] ModResetValue = 32'd1000000007;

	// Sequencer states, one-hot.
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_REDUCE = 5'b00010,
		ST_SQUARE = 5'b00100,
		ST_MULT   = 5'b01000,
		ST_FINISH = 5'b10000
	} mexp_state_t;

	// Status of the shared modular multiplier.
	typedef struct packed {
		logic busy;
		logic done;
	} mexp_mul_stat_t;

endpackage

/* hw/rtl/mexp_mulmod.sv */
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
`timescale 1ns / 1ps

module mexp_mulmod #(
	parameter int W = 31
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [W-1:0]              multiplicand,
	input  logic [W-1:0]              multiplier,
	input  logic [W-1:0]              modulus,
	output logic [W-1:0]              product,
	output mexp_pkg::mexp_mul_stat_t  stat
);
	import mexp_pkg::*;

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  acc_q;
	logic [W-1:0]  mcand_q;
	logic [W-1:0]  mplier_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [W:0]    dbl;
	logic [W:0]    dbl_red;
	logic [W:0]    sum;
	logic [W:0]    sum_red;

	// One step: double the accumulator and reduce, then add the multiplicand on a set bit
	// and reduce. The accumulator stays below the modulus throughout.
	always_comb begin
		dbl     = {acc_q, 1'b0};
		dbl_red = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
		sum     = dbl_red + (mplier_q[W-1] ? {1'b0, mcand_q} : {(W+1){1'b0}});
		sum_red = (sum >= {1'b0, modulus}) ? sum - {1'b0, modulus} : sum;
	end

	// Operand and accumulator registers.
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mcand_q  <= multiplicand;
			mplier_q <= multiplier;
		end else if (busy_q) begin
			acc_q    <= sum_red[W-1:0];
			mplier_q <= {mplier_q[W-2:0], 1'b0};
		end
	end

	// Step counter and status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CW'(1));
			if (start) begin
				cnt_q  <= CW'(W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign product   = acc_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

/* hw/rtl/modular_exponentiation.sv */
// Top level: square-and-multiply sequencer around the shared modular multiplier.
// Each item reduces the base, then squares for every exponent bit and multiplies for each
// set bit; a multiplication is issued, takes one bit step per multiplier bit and then
// signals completion. Throughput: one item at a time; in_stall is high from acceptance
// until the result is written to the output register. Modulus zero skips to a zero result.
// Reset: asynchronous, active low; clears control state and loads modulus 1000000007.
`timescale 1ns / 1ps

module modular_exponentiation #(
	parameter int EXP_WIDTH = 32,
	parameter int MOD_WIDTH = 31
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [MOD_WIDTH-1:0] modulus,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [MOD_WIDTH-1:0] base_value,
	input  logic [EXP_WIDTH-1:0] exponent,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [MOD_WIDTH-1:0] power_result
);
	import mexp_pkg::*;

	localparam int BW = $clog2(EXP_WIDTH + 1);
	localparam logic [MOD_WIDTH-1:0] ModReset = MOD_WIDTH'(ModResetValue);

	mexp_state_t           state_q;
	logic [MOD_WIDTH-1:0]  modulus_q;
	logic [MOD_WIDTH-1:0]  base_q;
	logic [EXP_WIDTH-1:0]  exp_q;
	logic [BW-1:0]         bit_cnt_q;
	logic [MOD_WIDTH-1:0]  run_q;
	logic [MOD_WIDTH-1:0]  res_q;
	logic                  out_valid_q;
	logic                  issue_q;

	logic                  in_accept;
	logic                  out_free;
	logic [MOD_WIDTH-1:0]  one_mod;
	logic [MOD_WIDTH-1:0]  mul_a;
	logic [MOD_WIDTH-1:0]  mul_b;
	logic [MOD_WIDTH-1:0]  mul_p;
	mexp_mul_stat_t        mul_stat;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;

	// One reduced modulo the modulus: zero when the modulus is one.
	assign one_mod = MOD_WIDTH'(modulus_q != MOD_WIDTH'(1));

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= ModReset;
		end else if (cfg_valid && cfg_ready) begin
			modulus_q <= modulus;
		end
	end

	// Operand selection for the shared multiplier. Base reduction multiplies one by the raw
	// base, so the multiplier scans the raw base bits.
	always_comb begin
		unique case (state_q)
			ST_REDUCE: begin
				mul_a = one_mod;
				mul_b = base_q;
			end
			ST_SQUARE: begin
				mul_a = run_q;
				mul_b = run_q;
			end
			ST_MULT: begin
				mul_a = run_q;
				mul_b = base_q;
			end
			default: begin
				mul_a = run_q;
				mul_b = base_q;
			end
		endcase
	end

	mexp_mulmod #(
		.W (MOD_WIDTH)
	) u_mulmod (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (issue_q),
		.multiplicand (mul_a),
		.multiplier   (mul_b),
		.modulus      (modulus_q),
		.product      (mul_p),
		.stat         (mul_stat)
	);

	// Sequencer: reduce the base, square and maybe multiply per exponent bit; modulus zero skips.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issue_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_FINISH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (modulus_q == '0) begin
							state_q <= ST_FINISH;
							issue_q <= 1'b0;
						end else begin
							state_q <= ST_REDUCE;
							issue_q <= 1'b1;
						end
					end else begin
						issue_q <= 1'b0;
					end
				end
				ST_REDUCE: begin
					if (mul_stat.done) begin
						state_q <= ST_SQUARE;
						issue_q <= 1'b1;
					end else begin
						issue_q <= 1'b0;
					end
				end
				ST_SQUARE, ST_MULT: begin
					if (mul_stat.done) begin
						if ((state_q == ST_SQUARE) && exp_q[EXP_WIDTH-1]) begin
							state_q <= ST_MULT;
							issue_q <= 1'b1;
						end else if (bit_cnt_q == BW'(1)) begin
							state_q <= ST_FINISH;
							issue_q <= 1'b0;
						end else begin
							state_q <= ST_SQUARE;
							issue_q <= 1'b1;
						end
					end else begin
						issue_q <= 1'b0;
					end
				end
				ST_FINISH: begin
					issue_q <= 1'b0;
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					issue_q <= 1'b0;
				end
			endcase
		end
	end

	// Datapath registers of the item in flight and the output register.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			base_q    <= base_value;
			exp_q     <= exponent;
			bit_cnt_q <= BW'(EXP_WIDTH);
			run_q     <= (modulus_q == '0) ? '0 : one_mod;
		end else if (mul_stat.done) begin
			if (state_q == ST_REDUCE) begin
				base_q <= mul_p;
			end else begin
				run_q <= mul_p;
				// Move to the next exponent bit once its square, and its multiply if the bit is set, are done.
				if ((state_q == ST_MULT) || !exp_q[EXP_WIDTH-1]) begin
					exp_q     <= exp_q << 1;
					bit_cnt_q <= bit_cnt_q - BW'(1);
				end
			end
		end
		if ((state_q == ST_FINISH) && out_free) begin
			res_q <= run_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign power_result = res_q;

	// The multiplier is only started while idle.
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		issue_q |-> !mul_stat.busy)
		else $error("multiplier started while busy");

	// Completions only arrive while the sequencer waits for one.
	a_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		mul_stat.done |-> (state_q == ST_REDUCE || state_q == ST_SQUARE || state_q == ST_MULT))
		else $error("unexpected multiplier completion");

	// The running value stays reduced while the exponent is scanned.
	a_run_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQUARE || state_q == ST_MULT) |-> (run_q < modulus_q))
		else $error("running value not reduced");

	// A delivered result is fully reduced when the modulus is nonzero.
	a_result_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && modulus_q != '0) |-> (res_q < modulus_q))
		else $error("result not reduced");

	// An accepted item always leaves the idle state.
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> (state_q != ST_IDLE))
		else $error("item accepted without starting work");

endmodule

/* test/tb_modular_exponentiation.sv */
// Self-checking testbench for the square-and-multiply modular exponentiation block.
`timescale 1ns / 1ps

module tb_modular_exponentiation;
	import mexp_pkg::*;

	localparam int EXP_W = 32;
	localparam int MOD_W = 31;
	// Slowest item: every exponent bit set, so one square and one multiply per bit.
	localparam int ITEM_LATENCY = (MOD_W + 3) * (1 + 2 * EXP_W) + 3;
	localparam int CYCLE_LIMIT = 5000000;
	localparam logic [MOD_W-1:0] MOD_MAX = {MOD_W{1'b1}};

	typedef struct {
		logic [MOD_W-1:0] base_in;
		logic [EXP_W-1:0] power_in;
	} power_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [MOD_W-1:0] modulus = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [MOD_W-1:0] base_value = '0;
	logic [EXP_W-1:0] exponent = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [MOD_W-1:0] power_result;

	power_item_t pending_items[$];
	logic [MOD_W-1:0] expected_powers[$];
	logic [MOD_W-1:0] active_modulus = ModResetValue[MOD_W-1:0];
	int in_idle_pct = 0;
	int out_stall_pct = 0;
	int fail_count = 0;
	int cycle_count = 0;

	modular_exponentiation #(
		.EXP_WIDTH(EXP_W),
		.MOD_WIDTH(MOD_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.modulus(modulus),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.base_value(base_value),
		.exponent(exponent),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.power_result(power_result)
	);

	// Clock with a 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Binary square-and-multiply over all exponent bits, most significant first.
	function automatic logic [MOD_W-1:0] predict_power(input logic [MOD_W-1:0] base_in,
			input logic [EXP_W-1:0] power_in, input logic [MOD_W-1:0] mod_in);
		longint unsigned m;
		longint unsigned b;
		longint unsigned acc;
		int i;
		if (mod_in == '0) begin
			return '0;
		end
		m = 64'(mod_in);
		b = 64'(base_in) % m;
		acc = 64'd1 % m;
		for (i = EXP_W - 1; i >= 0; i--) begin
			acc = (acc * acc) % m;
			if (power_in[i]) begin
				acc = (acc * b) % m;
			end
		end
		return acc[MOD_W-1:0];
	endfunction

	// Sender: presents queued items and records the expected power on acceptance.
	always @(posedge clk or negedge arst_n) begin : drive_items
		power_item_t next_item;
		logic busy;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			busy = in_valid;
			if (in_valid && !in_stall) begin
				expected_powers.insert(expected_powers.size(),
					predict_power(base_value, exponent, active_modulus));
				busy = 1'b0;
			end
			if (!busy) begin
				if (pending_items.size() > 0 && $urandom_range(0, 99) >= in_idle_pct) begin
					next_item = pending_items.pop_front();
					in_valid <= 1'b1;
					base_value <= next_item.base_in;
					exponent <= next_item.power_in;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls, and each accepted item is checked against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin : check_results
		logic [MOD_W-1:0] want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_powers.size() == 0) begin
					$display("%0t: unexpected power_result: expected none, actual %0d",
						$time, power_result);
					fail_count++;
				end else begin
					want = expected_powers.pop_front();
					if (power_result !== want) begin
						$display("%0t: power_result mismatch: expected %0d, actual %0d",
							$time, want, power_result);
						fail_count++;
					end
				end
			end
			out_stall <= ($urandom_range(0, 99) < out_stall_pct);
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic add_item(input logic [MOD_W-1:0] base_in, input logic [EXP_W-1:0] power_in);
		power_item_t item;
		item.base_in = base_in;
		item.power_in = power_in;
		pending_items.insert(pending_items.size(), item);
	endtask

	// Random items: a mix of full-range and corner values for both fields, and reduced bases.
	task automatic add_random(input int count);
		logic [MOD_W-1:0] b;
		logic [EXP_W-1:0] e;
		int n;
		for (n = 0; n < count; n++) begin
			case ($urandom_range(0, 9))
				0, 1, 2: b = MOD_W'($urandom);
				3, 4, 5: b = (active_modulus == '0) ? MOD_W'($urandom) :
					MOD_W'($urandom % active_modulus);
				6, 7: b = MOD_W'($urandom_range(0, 3));
				8: b = MOD_MAX - MOD_W'($urandom_range(0, 2));
				default: b = active_modulus - MOD_W'($urandom_range(0, 1));
			endcase
			case ($urandom_range(0, 7))
				0, 1, 2, 3: e = $urandom;
				4, 5: e = $urandom_range(0, 20);
				6: e = 32'd1 << $urandom_range(0, EXP_W - 1);
				default: e = ~($urandom_range(0, 3));
			endcase
			add_item(b, e);
		end
	endtask

	// Waits until every queued item has been accepted and every result has come.
	task automatic drain();
		do @(negedge clk);
		while (pending_items.size() != 0 || in_valid || expected_powers.size() != 0);
	endtask

	// Register write, only issued while the block holds no item.
	task automatic write_modulus(input logic [MOD_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		modulus <= value;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		active_modulus = value;
		@(negedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset modulus, sender idles lightly and receiver heavily.
		in_idle_pct = 17;
		out_stall_pct = 45;
		add_item('0, '0);
		add_item('0, 32'd1);
		add_item('0, '1);
		add_item(31'd1, '1);
		add_item(MOD_MAX, '0);
		add_item(MOD_MAX, '1);
		add_item(MOD_MAX, 32'd1);
		add_item(31'd2, 32'd30);
		add_item(31'd2, 32'h8000_0000);
		add_item(31'd3, 32'h5555_5555);
		add_item(31'd7, 32'hAAAA_AAAA);
		add_item(active_modulus, 32'd5);
		add_item(active_modulus - 31'd1, 32'd2);
		add_item(active_modulus - 31'd1, 32'd3);
		add_item(active_modulus + 31'd1, '1);
		add_item(31'h5555_5555, 32'h0000_FFFF);
		add_item(31'h2AAA_AAAA, 32'hFFFF_0000);
		add_item(31'd12345, EXP_W'(active_modulus - 31'd1));
		add_random(30);
		// The sender holds back here until every result is in.
		drain();
		add_random(30);
		drain();

		// Modulus one: every power is zero.
		write_modulus(31'd1);
		add_item('0, '0);
		add_item(MOD_MAX, '1);
		add_item(31'd1, '0);
		add_random(7);
		drain();

		// Largest modulus, receiver idles lightly and sender heavily.
		in_idle_pct = 45;
		out_stall_pct = 17;
		write_modulus(MOD_MAX);
		add_item(MOD_MAX, '1);
		add_item(MOD_MAX - 31'd1, 32'd2);
		add_item(MOD_MAX - 31'd1, '1);
		add_random(67);
		drain();

		// Modulus zero gives zero at once.
		write_modulus('0);
		add_item(MOD_MAX, '0);
		add_item(31'd5, 32'd3);
		add_random(6);
		drain();

		// Modulus two, no idling from here on.
		in_idle_pct = 0;
		out_stall_pct = 0;
		write_modulus(31'd2);
		add_item(31'd3, '0);
		add_item(31'd4, 32'd1);
		add_item(MOD_MAX, '1);
		add_random(7);
		drain();

		// Random modulus from 3 up to the largest value.
		write_modulus(MOD_W'($urandom_range(3, 32'h7FFF_FFFF)));
		add_random(60);
		drain();

		// Small prime, so reductions of large bases dominate.
		write_modulus(31'd13);
		add_item(31'd13, '0);
		add_item(31'd26, 32'd7);
		add_random(58);
		drain();

		repeat (ITEM_LATENCY) @(posedge clk);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
